### hdl/csv_field_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// CSV field tokenizer assertion macros
// Shared concurrent assertion forms; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset
`define CFTOK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cftok assertion failed");

// Next-cycle implication, disabled while in reset
`define CFTOK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cftok assertion failed");

`else

`define CFTOK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFTOK_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/cftok_pkg.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared types, codes and character constants of the tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cftok_pkg;

    localparam int BYTE_W         = 8;
    localparam int VALUE_W        = 32;
    localparam int FIELD_NUMBER_W = 16;
    localparam int RECORD_NUMBER_W = 32;
    localparam int CFG_INDEX_W    = 3;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_START      = 7'b0000001,
        PH_LEAD_WS    = 7'b0000010,
        PH_SIGN       = 7'b0000100,
        PH_DIGITS     = 7'b0001000,
        PH_TRAIL_WS   = 7'b0010000,
        PH_REST       = 7'b0100000,
        PH_QUOTE_SEEN = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        RK_TEXT      = 2'd0,
        RK_FIELD_END = 2'd1,
        RK_ERROR     = 2'd2
    } result_kind_t;

    localparam logic [1:0] FK_SIGNED   = 2'd0;
    localparam logic [1:0] FK_UNSIGNED = 2'd1;
    localparam logic [1:0] FK_TEXT     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_SEP  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_SEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KIND       = 3'd3;

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic [BYTE_W-1:0] field_sep;
        logic [BYTE_W-1:0] record_sep;
        logic [BYTE_W-1:0] quote;
        logic [1:0]        kind;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic               in_quotes;
        logic               negative_sign;
        logic               seen_digit;
        logic               field_spoiled;
        logic [VALUE_W-1:0] accumulator;
    } pstate_t;

    localparam pstate_t PSTATE_CLEAR = '{
        phase:         PH_START,
        in_quotes:     1'b0,
        negative_sign: 1'b0,
        seen_digit:    1'b0,
        field_spoiled: 1'b0,
        accumulator:   '0
    };

    typedef struct packed {
        logic               emit;
        result_kind_t       kind;
        logic [BYTE_W-1:0]  text;
        logic [VALUE_W-1:0] value;
        logic               ok;
        logic               ends;
        logic               halt;
        logic               next_field;
        logic               next_record;
    } step_out_t;

endpackage

### hdl/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Splits a byte stream into CSV fields, passes text or converts decimals.
// ----------------------------------------------------------------------------
//  channel | signals                                        | moves
//  --------+------------------------------------------------+------------------
//  in      | in_valid, in_ready, data_byte, end_of_input    | one byte request
//  out     | out_valid, out_ready, result_kind .. record_num| one result request
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | one register write
//
//  A byte request is held in the input register; the parse step loads
//  its result, if any, into the result register once that can take it.
//  One byte per cycle unless the output stalls, set by the single parse
//  step and its times-ten add. A stalled output holds its result and the
//  held byte, even one with no result; meanwhile in_ready stays low.
//  Reset clears parse state, counters, error latch and registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "csv_field_tokenizer_core_defines.svh"

module csv_field_tokenizer_core #(
    parameter int FIELD_INDEX_BITS  = 16,
    parameter int RECORD_INDEX_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input byte channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [cftok_pkg::BYTE_W-1:0]        data_byte,
    input  logic                                end_of_input,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          result_kind,
    output logic [cftok_pkg::BYTE_W-1:0]        text_byte,
    output logic [cftok_pkg::VALUE_W-1:0]       field_value,
    output logic                                conversion_ok,
    output logic                                ends_record,
    output logic [cftok_pkg::FIELD_NUMBER_W-1:0]  field_number,
    output logic [cftok_pkg::RECORD_NUMBER_W-1:0] record_number,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cftok_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cftok_pkg::BYTE_W-1:0]        cfg_data
);

    localparam int FN_W = cftok_pkg::FIELD_NUMBER_W;
    localparam int RN_W = cftok_pkg::RECORD_NUMBER_W;

    cftok_pkg::cfg_t      cfg;
    cftok_pkg::pstate_t   pstate_reg;
    cftok_pkg::pstate_t   pstate_next;
    cftok_pkg::pstate_t   step_state;
    cftok_pkg::step_out_t step_res;

    // input register
    logic                         in_valid_reg;
    logic [cftok_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         in_eoi_reg;

    // running counters and error latch
    logic [FIELD_INDEX_BITS-1:0]  field_cnt_reg;
    logic [FIELD_INDEX_BITS-1:0]  field_cnt_next;
    logic [RECORD_INDEX_BITS-1:0] rec_cnt_reg;
    logic [RECORD_INDEX_BITS-1:0] rec_cnt_next;
    logic                         halted_reg;
    logic                         halted_next;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    cftok_pkg::result_kind_t       kind_reg;
    logic [cftok_pkg::BYTE_W-1:0]  text_reg;
    logic [cftok_pkg::VALUE_W-1:0] value_reg;
    logic                          ok_reg;
    logic                          ends_reg;
    logic [FN_W-1:0]               fnum_reg;
    logic [RN_W-1:0]               rnum_reg;

    logic process;
    logic live;
    logic load_result;

    cftok_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cftok_step u_step (
        .cfg          (cfg),
        .data_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .cur          (pstate_reg),
        .nxt          (step_state),
        .res          (step_res)
    );

    // Advance the held byte once the result register can take its result
    assign process     = in_valid_reg && (!out_valid_reg || out_ready);
    assign live        = process && !halted_reg;
    assign load_result = live && step_res.emit;
    assign in_ready    = !in_valid_reg || process;

    always_comb
    begin
        pstate_next    = pstate_reg;
        field_cnt_next = field_cnt_reg;
        rec_cnt_next   = rec_cnt_reg;
        halted_next    = halted_reg;
        if (live)
        begin
            pstate_next = step_state;
            halted_next = step_res.halt;
            if (step_res.next_field)
                field_cnt_next = field_cnt_reg + FIELD_INDEX_BITS'(1);
            if (step_res.next_record)
            begin
                field_cnt_next = '0;
                rec_cnt_next   = rec_cnt_reg + RECORD_INDEX_BITS'(1);
            end
        end

        priority if (load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pstate_reg    <= cftok_pkg::PSTATE_CLEAR;
            field_cnt_reg <= '0;
            rec_cnt_reg   <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            pstate_reg    <= pstate_next;
            field_cnt_reg <= field_cnt_next;
            rec_cnt_reg   <= rec_cnt_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_eoi_reg  <= end_of_input;
        end
        if (load_result)
        begin
            kind_reg  <= step_res.kind;
            text_reg  <= step_res.text;
            value_reg <= step_res.value;
            ok_reg    <= step_res.ok;
            ends_reg  <= step_res.ends;
            fnum_reg  <= FN_W'(field_cnt_reg);
            rnum_reg  <= RN_W'(rec_cnt_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign text_byte     = text_reg;
    assign field_value   = value_reg;
    assign conversion_ok = ok_reg;
    assign ends_record   = ends_reg;
    assign field_number  = fnum_reg;
    assign record_number = rnum_reg;

    // Error latch never clears without reset
    `CFTOK_ASSERT_NXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg)
    // An error result is only ever shown once the block has halted
    `CFTOK_ASSERT_IMP(a_error_halts, clk, rst_n,
        out_valid_reg && (kind_reg == cftok_pkg::RK_ERROR), halted_reg)
    // A fresh field carries no leftovers from the last one
    `CFTOK_ASSERT_IMP(a_start_clean, clk, rst_n,
        pstate_reg.phase == cftok_pkg::PH_START,
        !pstate_reg.in_quotes && !pstate_reg.seen_digit
        && !pstate_reg.field_spoiled && (pstate_reg.accumulator == '0))
    // A failed conversion reports a zero value
    `CFTOK_ASSERT_IMP(a_bad_value_zero, clk, rst_n,
        out_valid_reg && !ok_reg, value_reg == '0)
    // Once halted, no further result is loaded
    `CFTOK_ASSERT_NXT(a_halt_silent, clk, rst_n,
        halted_reg && !out_valid_reg, !out_valid_reg)

endmodule

### hdl/cftok_cfg.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer configuration registers
// Separator, quote and field-kind registers behind a valid/ready write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cftok_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cftok_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cftok_pkg::BYTE_W-1:0]          cfg_data,
    output cftok_pkg::cfg_t                       cfg
);

    cftok_pkg::cfg_t cfg_reg;
    cftok_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                cftok_pkg::CFG_FIELD_SEP:  cfg_next.field_sep  = cfg_data;
                cftok_pkg::CFG_RECORD_SEP: cfg_next.record_sep = cfg_data;
                cftok_pkg::CFG_QUOTE:      cfg_next.quote      = cfg_data;
                cftok_pkg::CFG_KIND:       cfg_next.kind       = cfg_data[1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_sep  <= cftok_pkg::CH_COMMA;
            cfg_reg.record_sep <= cftok_pkg::CH_LF;
            cfg_reg.quote      <= cftok_pkg::CH_DQUOTE;
            cfg_reg.kind       <= cftok_pkg::FK_SIGNED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/cftok_step.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer parse step
// Combinational next state and result for one byte or end-of-input mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cftok_step (
    input  cftok_pkg::cfg_t                 cfg,
    input  logic [cftok_pkg::BYTE_W-1:0]    data_byte,
    input  logic                            end_of_input,
    input  cftok_pkg::pstate_t              cur,
    output cftok_pkg::pstate_t              nxt,
    output cftok_pkg::step_out_t            res
);

    localparam int VW = cftok_pkg::VALUE_W;

    logic numeric;
    logic signed_mode;
    logic ws;
    logic sign_hit;
    logic digit_hit;
    logic is_q;
    logic is_fs;
    logic is_rs;
    logic from_lead;
    logic from_sign;
    logic from_digits;
    logic from_trail;
    logic go_rest;
    logic go_qseen;
    logic reach_sign;
    logic reach_digits;
    logic reach_trail;
    logic reach_rest;
    logic do_content;
    logic do_end;
    logic end_rec;
    logic do_error;
    logic [VW-1:0] acc_times_ten;
    logic [VW-1:0] digit_value;
    logic          field_ok;

    assign numeric     = !cfg.kind[1];
    assign signed_mode = (cfg.kind == cftok_pkg::FK_SIGNED);
    assign is_q        = !end_of_input && (data_byte == cfg.quote);
    assign is_fs       = !end_of_input && (data_byte == cfg.field_sep);
    assign is_rs       = end_of_input || (data_byte == cfg.record_sep);

    // Whitespace never swallows a separator
    assign ws = !end_of_input
             && (data_byte != cfg.field_sep) && (data_byte != cfg.record_sep)
             && ((data_byte == cftok_pkg::CH_SPACE)
                 || ((data_byte >= cftok_pkg::CH_TAB) && (data_byte <= cftok_pkg::CH_CR)));

    assign sign_hit  = signed_mode && !end_of_input
                    && ((data_byte == cftok_pkg::CH_MINUS) || (data_byte == cftok_pkg::CH_PLUS));
    assign digit_hit = !end_of_input
                    && (data_byte >= cftok_pkg::CH_ZERO) && (data_byte <= cftok_pkg::CH_NINE);

    assign digit_value   = VW'(data_byte - cftok_pkg::CH_ZERO);
    assign acc_times_ten = {cur.accumulator[VW-4:0], 3'b000}
                         + {cur.accumulator[VW-2:0], 1'b0};

    assign field_ok = numeric && cur.seen_digit && !cur.field_spoiled;

    // Chain of phases that the byte passes through before it is consumed
    assign reach_sign   = (from_lead && !ws) || from_sign;
    assign reach_digits = (reach_sign && !sign_hit) || from_digits;
    assign reach_trail  = (reach_digits && !digit_hit) || from_trail;
    assign reach_rest   = (reach_trail && !ws) || go_rest;

    always_comb
    begin
        nxt         = cur;
        from_lead   = 1'b0;
        from_sign   = 1'b0;
        from_digits = 1'b0;
        from_trail  = 1'b0;
        go_rest     = 1'b0;
        go_qseen    = 1'b0;
        do_content  = 1'b0;
        do_end      = 1'b0;
        end_rec     = 1'b0;
        do_error    = 1'b0;

        unique case (cur.phase)
            cftok_pkg::PH_START:
            begin
                if (is_q)
                begin
                    nxt.in_quotes = 1'b1;
                    nxt.phase     = numeric ? cftok_pkg::PH_LEAD_WS : cftok_pkg::PH_REST;
                end
                else if (numeric)
                    from_lead = 1'b1;
                else
                    go_rest = 1'b1;
            end
            cftok_pkg::PH_LEAD_WS:    begin from_lead   = numeric; go_rest = !numeric; end
            cftok_pkg::PH_SIGN:       begin from_sign   = numeric; go_rest = !numeric; end
            cftok_pkg::PH_DIGITS:     begin from_digits = numeric; go_rest = !numeric; end
            cftok_pkg::PH_TRAIL_WS:   begin from_trail  = numeric; go_rest = !numeric; end
            cftok_pkg::PH_REST:       go_rest  = 1'b1;
            cftok_pkg::PH_QUOTE_SEEN: go_qseen = 1'b1;
            default:                  nxt.phase = cftok_pkg::PH_START;
        endcase

        priority if (from_lead && ws)
        begin
            nxt.phase = cftok_pkg::PH_LEAD_WS;
        end
        else if (reach_sign && sign_hit)
        begin
            nxt.phase         = cftok_pkg::PH_DIGITS;
            nxt.negative_sign = (data_byte == cftok_pkg::CH_MINUS);
        end
        else if (reach_digits && digit_hit)
        begin
            nxt.phase       = cftok_pkg::PH_DIGITS;
            nxt.accumulator = acc_times_ten + digit_value;
            nxt.seen_digit  = 1'b1;
        end
        else if (reach_trail && ws)
        begin
            nxt.phase = cftok_pkg::PH_TRAIL_WS;
        end
        else if (reach_rest)
        begin
            nxt.phase = cftok_pkg::PH_REST;
            if (cur.in_quotes)
            begin
                priority if (end_of_input) do_error = 1'b1;
                else if (is_q)             nxt.phase = cftok_pkg::PH_QUOTE_SEEN;
                else                       do_content = 1'b1;
            end
            else
            begin
                priority if (is_fs)              do_end = 1'b1;
                else if (is_rs)                  begin do_end = 1'b1; end_rec = 1'b1; end
                else if (data_byte == cfg.quote) do_error = 1'b1;
                else                             do_content = 1'b1;
            end
        end
        else if (go_qseen)
        begin
            priority if (is_q)
            begin
                nxt.phase  = cftok_pkg::PH_REST;
                do_content = 1'b1;
            end
            else if (is_fs)  do_end = 1'b1;
            else if (is_rs)  begin do_end = 1'b1; end_rec = 1'b1; end
            else             do_error = 1'b1;
        end
        else
        begin
            nxt.phase = nxt.phase;
        end

        // Numeric fields fold content into a spoiled flag
        if (do_content && numeric)
            nxt.field_spoiled = 1'b1;
        if (do_end)
            nxt = cftok_pkg::PSTATE_CLEAR;
    end

    always_comb
    begin
        res             = '0;
        res.kind        = cftok_pkg::RK_TEXT;
        res.halt        = do_error;
        res.next_field  = do_end && !end_rec;
        res.next_record = do_end && end_rec;
        priority if (do_error)
        begin
            res.emit = 1'b1;
            res.kind = cftok_pkg::RK_ERROR;
        end
        else if (do_end)
        begin
            res.emit  = 1'b1;
            res.kind  = cftok_pkg::RK_FIELD_END;
            res.ok    = field_ok;
            res.ends  = end_rec;
            res.value = !field_ok          ? '0
                      : cur.negative_sign  ? (VW'(0) - cur.accumulator)
                      :                      cur.accumulator;
        end
        else if (do_content && !numeric)
        begin
            res.emit = 1'b1;
            res.text = data_byte;
        end
        else
        begin
            res.emit = 1'b0;
        end
    end

endmodule

### test/csv_field_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer result checker
// Watches the byte, result and register channels, predicts every result of
// each accepted byte request and compares it field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_tokenizer_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic [cftok_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                  end_of_input,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic [1:0]                            result_kind,
    input  logic [cftok_pkg::BYTE_W-1:0]          text_byte,
    input  logic [cftok_pkg::VALUE_W-1:0]         field_value,
    input  logic                                  conversion_ok,
    input  logic                                  ends_record,
    input  logic [cftok_pkg::FIELD_NUMBER_W-1:0]  field_number,
    input  logic [cftok_pkg::RECORD_NUMBER_W-1:0] record_number,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [cftok_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cftok_pkg::BYTE_W-1:0]          cfg_data,
    output int                                    mismatch_count,
    output int                                    open_results
);

    import cftok_pkg::*;

    typedef struct packed {
        result_kind_t               kind;
        logic [BYTE_W-1:0]          text;
        logic [VALUE_W-1:0]         value;
        logic                       ok;
        logic                       ends;
        logic [FIELD_NUMBER_W-1:0]  field;
        logic [RECORD_NUMBER_W-1:0] record;
    } token_t;

    // Register copy and parse state of the tokenizer
    cfg_t                       regs;
    phase_t                     phase;
    logic                       quoted;
    logic                       negative;
    logic                       have_digit;
    logic                       spoiled;
    logic                       halted;
    logic [VALUE_W-1:0]         acc;
    logic [FIELD_NUMBER_W-1:0]  field_idx;
    logic [RECORD_NUMBER_W-1:0] record_idx;

    token_t expected_tokens[$];
    token_t want;
    int     errors;

    function automatic void push_token(result_kind_t kind, logic [BYTE_W-1:0] text,
                                       logic [VALUE_W-1:0] value, logic ok, logic ends);
        token_t t;
        t.kind   = kind;
        t.text   = text;
        t.value  = value;
        t.ok     = ok;
        t.ends   = ends;
        t.field  = field_idx;
        t.record = record_idx;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void clear_field();
        phase      = PH_START;
        quoted     = 1'b0;
        negative   = 1'b0;
        have_digit = 1'b0;
        spoiled    = 1'b0;
        acc        = '0;
    endfunction

    function automatic void close_field(logic at_record, logic numeric);
        logic               ok;
        logic [VALUE_W-1:0] v;
        ok = numeric && have_digit && !spoiled;
        v  = '0;
        if (ok)
            v = negative ? (32'd0 - acc) : acc;
        push_token(RK_FIELD_END, '0, v, ok, at_record);
        if (at_record)
        begin
            field_idx  = '0;
            record_idx = record_idx + RECORD_NUMBER_W'(1);
        end
        else
            field_idx = field_idx + FIELD_NUMBER_W'(1);
        clear_field();
    endfunction

    function automatic void raise_format_error();
        push_token(RK_ERROR, '0, '0, 1'b0, 1'b0);
        halted = 1'b1;
    endfunction

    // Numeric fields swallow content bytes and lose their ok flag
    function automatic void take_content(logic [BYTE_W-1:0] c, logic numeric);
        if (numeric)
            spoiled = 1'b1;
        else
            push_token(RK_TEXT, c, '0, 1'b0, 1'b0);
    endfunction

    function automatic logic is_blank(logic [BYTE_W-1:0] c, logic eoi);
        if (eoi || c == regs.field_sep || c == regs.record_sep)
            return 1'b0;
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Advance the parse state by one byte request; queue any result it gives
    function automatic void tokenize_byte(logic [BYTE_W-1:0] c, logic eoi);
        logic numeric;
        logic signed_mode;
        logic done;
        numeric     = !regs.kind[1];
        signed_mode = regs.kind == FK_SIGNED;
        done        = halted;
        while (!done)
        begin
            done = 1'b1;
            case (phase)
                PH_START:
                begin
                    phase = numeric ? PH_LEAD_WS : PH_REST;
                    if (!eoi && c == regs.quote)
                        quoted = 1'b1;
                    else
                        done = 1'b0;
                end
                PH_LEAD_WS, PH_TRAIL_WS:
                begin
                    if (!numeric)
                    begin
                        phase = PH_REST;
                        done  = 1'b0;
                    end
                    else if (!is_blank(c, eoi))
                    begin
                        phase = (phase == PH_LEAD_WS) ? PH_SIGN : PH_REST;
                        done  = 1'b0;
                    end
                end
                PH_SIGN:
                begin
                    if (!numeric)
                    begin
                        phase = PH_REST;
                        done  = 1'b0;
                    end
                    else
                    begin
                        phase = PH_DIGITS;
                        if (signed_mode && !eoi && (c == CH_MINUS || c == CH_PLUS))
                            negative = (c == CH_MINUS);
                        else
                            done = 1'b0;
                    end
                end
                PH_DIGITS:
                begin
                    if (!numeric)
                    begin
                        phase = PH_REST;
                        done  = 1'b0;
                    end
                    else if (!eoi && c >= CH_ZERO && c <= CH_NINE)
                    begin
                        acc        = acc * 32'd10 + VALUE_W'(c - CH_ZERO);
                        have_digit = 1'b1;
                    end
                    else
                    begin
                        phase = PH_TRAIL_WS;
                        done  = 1'b0;
                    end
                end
                PH_REST:
                begin
                    if (quoted)
                    begin
                        if (eoi)
                            raise_format_error();
                        else if (c == regs.quote)
                            phase = PH_QUOTE_SEEN;
                        else
                            take_content(c, numeric);
                    end
                    else if (!eoi && c == regs.field_sep)
                        close_field(1'b0, numeric);
                    else if (eoi || c == regs.record_sep)
                        close_field(1'b1, numeric);
                    else if (c == regs.quote)
                        raise_format_error();
                    else
                        take_content(c, numeric);
                end
                PH_QUOTE_SEEN:
                begin
                    if (!eoi && c == regs.quote)
                    begin
                        phase = PH_REST;
                        take_content(c, numeric);
                    end
                    else if (!eoi && c == regs.field_sep)
                        close_field(1'b0, numeric);
                    else if (eoi || c == regs.record_sep)
                        close_field(1'b1, numeric);
                    else
                        raise_format_error();
                end
                default:
                begin
                    phase = PH_START;
                    done  = 1'b0;
                end
            endcase
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            regs.field_sep  = CH_COMMA;
            regs.record_sep = CH_LF;
            regs.quote      = CH_DQUOTE;
            regs.kind       = FK_SIGNED;
            clear_field();
            field_idx  = '0;
            record_idx = '0;
            halted     = 1'b0;
            errors     = 0;
            expected_tokens.delete();
        end
        else
        begin
            // Compare before predicting: a byte taken now cannot have a result yet
            if (out_valid && out_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with nothing expected: kind=%0d text=%h value=%h",
                                 $realtime, result_kind, text_byte, field_value);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (want.kind !== result_kind || want.text !== text_byte ||
                        want.value !== field_value || want.ok !== conversion_ok ||
                        want.ends !== ends_record || want.field !== field_number ||
                        want.record !== record_number)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected kind=%0d text=%h value=%h ok=%b ends=%b f=%0d r=%0d",
                                     want.kind, want.text, want.value, want.ok, want.ends,
                                     want.field, want.record);
                            $display("  actual   kind=%0d text=%h value=%h ok=%b ends=%b f=%0d r=%0d",
                                     result_kind, text_byte, field_value, conversion_ok,
                                     ends_record, field_number, record_number);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIELD_SEP:  regs.field_sep  = cfg_data;
                    CFG_RECORD_SEP: regs.record_sep = cfg_data;
                    CFG_QUOTE:      regs.quote      = cfg_data;
                    CFG_KIND:       regs.kind       = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                tokenize_byte(data_byte, end_of_input);
        end
        mismatch_count <= errors;
        open_results   <= expected_tokens.size();
    end

endmodule

### test/csv_field_tokenizer_core_tb.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer core testbench
// Drives directed and random CSV byte streams through the tokenizer under
// several separator, quote and field-kind settings with random idling on
// both channels; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_tokenizer_core_tb;

    import cftok_pkg::*;

    // Field kind 3 has no name of its own in the package; it behaves as text
    localparam logic [1:0] FK_TEXT_ALIAS = 2'd3;
    localparam int         HOLD_CYCLES   = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic [BYTE_W-1:0]          data_byte    = '0;
    logic                       end_of_input = 1'b0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic [1:0]                 result_kind;
    logic [BYTE_W-1:0]          text_byte;
    logic [VALUE_W-1:0]         field_value;
    logic                       conversion_ok;
    logic                       ends_record;
    logic [FIELD_NUMBER_W-1:0]  field_number;
    logic [RECORD_NUMBER_W-1:0] record_number;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index    = '0;
    logic [BYTE_W-1:0]          cfg_data     = '0;

    int   mismatch_count;
    int   open_results;

    // Idling knobs, written by the stimulus process only
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_arm       = 1'b0;

    // Long hold-off bookkeeping, owned by the receiver process
    int   hold_left = 0;
    logic hold_used = 1'b0;

    // Register values currently programmed, used to shape the stream
    logic [BYTE_W-1:0] cur_fs   = CH_COMMA;
    logic [BYTE_W-1:0] cur_rs   = CH_LF;
    logic [BYTE_W-1:0] cur_q    = CH_DQUOTE;
    logic [1:0]        cur_kind = FK_SIGNED;
    int                bytes_sent = 0;

    always #1 clk = ~clk;

    csv_field_tokenizer_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_input  (end_of_input),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .text_byte     (text_byte),
        .field_value   (field_value),
        .conversion_ok (conversion_ok),
        .ends_record   (ends_record),
        .field_number  (field_number),
        .record_number (record_number),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    csv_field_tokenizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_input   (end_of_input),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .text_byte      (text_byte),
        .field_value    (field_value),
        .conversion_ok  (conversion_ok),
        .ends_record    (ends_record),
        .field_number   (field_number),
        .record_number  (record_number),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .open_results   (open_results)
    );

    // Result side: stall at random, or hold off for a long stretch once when
    // armed so the block fills up and pushes back on the byte channel.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_used)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Quoted fields are only safe when no separator doubles as the quote:
    // at field start the quote check comes first.
    function automatic logic quoting_ok();
        return cur_fs != cur_q && cur_rs != cur_q;
    endfunction

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == cur_fs || b == cur_rs || b == cur_q);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] any_but_quote();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == cur_q);
        return b;
    endfunction

    // Keep structural bytes away from the quote character
    function automatic logic [BYTE_W-1:0] safe(logic [BYTE_W-1:0] b);
        return (b == cur_q) ? plain_byte() : b;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_byte();
        if ($urandom_range(0, 5) == 0)
            return CH_SPACE;
        return CH_TAB + BYTE_W'($urandom_range(0, 4));
    endfunction

    // Offer one byte request after a random gap; hold it until taken.
    // Valid stays high on return; settle() drops it.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eoi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s.getc(i), 1'b0);
    endtask

    // Drop valid and wait until every expected result has drained, then
    // give the pipeline time to finish a byte that yields nothing.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (open_results != 0);
        repeat (4) @(posedge clk);
    endtask

    // Valid stays high across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [BYTE_W-1:0] fs, input logic [BYTE_W-1:0] rs,
                                input logic [BYTE_W-1:0] q, input logic [1:0] kind);
        settle();
        write_reg(CFG_FIELD_SEP, fs);
        write_reg(CFG_RECORD_SEP, rs);
        write_reg(CFG_QUOTE, q);
        write_reg(CFG_KIND, BYTE_W'(kind));
        cfg_valid <= 1'b0;
        cur_fs   = fs;
        cur_rs   = rs;
        cur_q    = q;
        cur_kind = kind;
    endtask

    // One field shaped for the current kind: optional quotes, blanks, sign,
    // digits (sometimes enough to wrap), and now and then a stray byte.
    task automatic send_field();
        logic quoted;
        int   len;
        quoted = quoting_ok() && ($urandom_range(0, 3) == 0);
        if (quoted)
            send_byte(cur_q, 1'b0);
        if (cur_kind[1])
        begin
            len = $urandom_range(quoting_ok() ? 0 : 1, 6);
            repeat (len)
            begin
                if (quoted && $urandom_range(0, 7) == 0)
                begin
                    send_byte(cur_q, 1'b0);
                    send_byte(cur_q, 1'b0);
                end
                else
                    send_byte(quoted ? any_but_quote() : plain_byte(), 1'b0);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 2)) send_byte(safe(blank_byte()), 1'b0);
            if ($urandom_range(0, 2) == 0)
                send_byte(safe($urandom_range(0, 1) ? CH_MINUS : CH_PLUS), 1'b0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
            if (len == 0 && !quoting_ok())
                len = 1;
            repeat (len) send_byte(safe(CH_ZERO + BYTE_W'($urandom_range(0, 9))), 1'b0);
            repeat ($urandom_range(0, 1)) send_byte(safe(blank_byte()), 1'b0);
            if ($urandom_range(0, 5) == 0)
            begin
                if (quoted && $urandom_range(0, 1) == 0)
                begin
                    send_byte(cur_q, 1'b0);
                    send_byte(cur_q, 1'b0);
                end
                else
                    send_byte(quoted ? any_but_quote() : plain_byte(), 1'b0);
            end
        end
        if (quoted)
            send_byte(cur_q, 1'b0);
    endtask

    task automatic send_record();
        int n_fields;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++)
        begin
            send_field();
            if (f < n_fields - 1)
                send_byte(cur_fs, 1'b0);
        end
        // Close with end of input now and then; its data byte is don't-care
        if ($urandom_range(0, 9) == 0)
            send_byte(BYTE_W'($urandom), 1'b1);
        else
            send_byte(cur_rs, 1'b0);
    endtask

    // Program a setting, set the idling, then stream records until the
    // byte budget is spent. Noise lines never carry the quote character.
    task automatic run_phase(input logic [BYTE_W-1:0] fs, input logic [BYTE_W-1:0] rs,
                             input logic [BYTE_W-1:0] q, input logic [1:0] kind,
                             input int idle_in, input int idle_out, input int budget,
                             input logic hold);
        int start;
        program_regs(fs, rs, q, kind);
        send_idle_pct  <= idle_in;
        recv_stall_pct <= idle_out;
        hold_arm       <= hold;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            if (quoting_ok() && $urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_byte(any_but_quote(), 1'b0);
                send_byte(cur_rs, 1'b0);
            end
            send_record();
        end
    endtask

    // Safety net against a hung handshake
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: signed integers
        send_text(" -12 ,");            // blanks around a negative number
        send_text("x5\n");              // stray letter spoils, record ends
        send_text(",");                 // empty field: no digits
        send_text("-");                 // lone sign closed by end of input
        send_byte(8'h5A, 1'b1);
        program_regs(CH_COMMA, CH_LF, CH_DQUOTE, FK_UNSIGNED);
        send_text("+5\n");              // sign is stray in unsigned mode
        program_regs(CH_COMMA, CH_LF, CH_DQUOTE, FK_SIGNED);
        send_text("-4");                // leave a numeric field half parsed
        program_regs(CH_COMMA, CH_LF, CH_DQUOTE, FK_TEXT);
        send_text("z,");                // text mode carries on with it
        send_byte(CH_DQUOTE, 1'b0);     // quoted: extreme bytes, separator,
        send_byte(8'h00, 1'b0);         // doubled quote as content
        send_text(",\"\"");
        send_byte(8'hFF, 1'b0);
        send_text("\"\n");
        send_byte(8'hA5, 1'b1);         // end of input on an empty field

        // Random part across settings and idling patterns
        run_phase(CH_COMMA, CH_LF, CH_DQUOTE, FK_SIGNED, 0, 0, 160, 1'b0);
        run_phase(CH_COMMA, CH_LF, CH_DQUOTE, FK_UNSIGNED, 46, 0, 160, 1'b0);
        run_phase(CH_COMMA, CH_LF, CH_DQUOTE, FK_TEXT, 0, 46, 160, 1'b1);
        // Field separator equals record separator: field separator wins
        run_phase(8'hFF, 8'hFF, 8'h00, FK_SIGNED, 7, 7, 160, 1'b0);
        // Separators on a blank character, which then is no blank
        run_phase(CH_TAB, CH_TAB, 8'h27, FK_TEXT_ALIAS, 0, 0, 150, 1'b0);
        // Record separator equals quote: past field start and outside quotes it ends the record
        run_phase(8'h3B, 8'h7C, 8'h7C, FK_UNSIGNED, 0, 46, 160, 1'b0);
        run_phase(8'h00, 8'hFF, CH_DQUOTE, FK_TEXT, 46, 46, 80, 1'b0);

        // The format error latches until reset, so break the stream last
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte(plain_byte(), 1'b0);
                send_byte(cur_q, 1'b0);
            end
            1:
            begin
                send_byte(cur_q, 1'b0);
                send_byte(plain_byte(), 1'b0);
                send_byte(BYTE_W'($urandom), 1'b1);
            end
            default:
            begin
                send_byte(cur_q, 1'b0);
                send_byte(plain_byte(), 1'b0);
                send_byte(cur_q, 1'b0);
                send_byte(plain_byte(), 1'b0);
            end
        endcase
        // Everything after the error must stay silent
        repeat (6) send_byte(BYTE_W'($urandom), 1'($urandom_range(0, 1)));

        settle();
        if (mismatch_count == 0 && open_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
